### rtl/rsa_pkg.sv
// shared types and constants of the region slot allocator
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [ADDR_W-1:0]  BASE_RESET = 32'h0040_0000;

  // request codes, code 3 is unknown and does nothing
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  // write request toward the slot table
  typedef struct packed {
    logic              we_start;
    logic              we_size;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } slot_wr_t;

endpackage

`default_nettype wire

### rtl/rsa_if.sv
// request and response channel interfaces of the region slot allocator
`timescale 1ns / 1ps
`default_nettype none

interface rsa_req_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] size_bytes;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output req_type, output size_bytes, output address,
                  input ready);
  modport sink   (input valid, input req_type, input size_bytes, input address,
                  output ready);
endinterface

interface rsa_rsp_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic              legitimate;

  modport source (output valid, output result_address, output legitimate, input ready);
  modport sink   (input valid, input result_address, input legitimate, output ready);
endinterface

`default_nettype wire

### rtl/rsa_slot_mem.sv
// slot table memory: start and size arrays, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rsa_slot_mem import rsa_pkg::*; #(
  parameter int unsigned SLOTS = 512,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  wire logic              clk,
  input  wire slot_wr_t          wr,
  input  wire logic [IW-1:0]     wr_idx,
  input  wire logic              rd_en,
  input  wire logic [IW-1:0]     rd_idx,
  output logic      [ADDR_W-1:0] rd_start,
  output logic      [ADDR_W-1:0] rd_size
);

  logic [ADDR_W-1:0] start_mem [SLOTS];
  logic [ADDR_W-1:0] size_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we_start) begin
      start_mem[wr_idx] <= wr.start;
    end
    if (wr.we_size) begin
      size_mem[wr_idx] <= wr.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= start_mem[rd_idx];
      rd_size  <= size_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

### rtl/rsa_page_round.sv
// page rounding unit: masks off the in-page offset, then rounds up to whole pages with saturation
`timescale 1ns / 1ps
`default_nettype none

module rsa_page_round import rsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] bytes,
  output logic                   done,
  output logic      [ADDR_W-1:0] need
);

  // page size is a power of two, so the in-page offset is a mask
  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
  localparam longint unsigned SAT_L = (64'hFFFF_FFFF / PAGE_BYTES) * PAGE_BYTES;
  localparam logic [ADDR_W-1:0] SAT_V = ADDR_W'(SAT_L);

  logic              fin_r;
  logic [ADDR_W-1:0] bytes_r;
  logic [ADDR_W:0]   total;

  // whole pages below the size plus one page when an offset is left, 33 bits to see overflow
  assign total = {1'b0, bytes_r & ~PAGE_MASK}
               + (((bytes_r & PAGE_MASK) != '0) ? (ADDR_W+1)'(PAGE_BYTES) : '0);

  assign need = total[ADDR_W] ? SAT_V : total[ADDR_W-1:0];
  assign done = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bytes_r <= bytes;
    end
  end

endmodule

`default_nettype wire

### rtl/region_slot_allocator.sv
// region slot allocator top level: sequencer, scan datapath and configuration register
//
// usage: requests arrive on in_req (allocate, release, check) and each gives one
// transaction on out_rsp carrying result_address and legitimate. base_address is
// written through cfg_we / cfg_wdata; the user must write it only while the block
// is idle, the block itself does not enforce this. an allocate first registers the
// size in the page rounding unit, then scans the slot table one slot per cycle
// through the single read port of the slot memory until the first usable slot is
// found; with no live region it writes slot 0 directly. release of a nonzero
// address and check always scan all SLOTS slots; release of address 0 and unknown
// codes skip the scan. one request is in work at a time: the sequencer takes no new
// request before it has passed the last one's result to the output register.
// after reset the block sweeps the table clear, one slot per cycle, and
// in_req.ready stays low meanwhile. a finished result waits in the output
// register while out_rsp is stalled; the next request may be accepted then, and
// its result is held back until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module region_slot_allocator import rsa_pkg::*; #(
  parameter int unsigned SLOTS      = 512,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rsa_req_if.sink                in_req,
  rsa_rsp_if.source              out_rsp,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(SLOTS);

  state_t             state_r, state_nxt;
  logic [IW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [COUNT_W-1:0] live_r, live_nxt;
  logic [ADDR_W-1:0]  base_r;
  logic [1:0]         req_r, req_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  need_r, need_nxt;
  logic [ADDR_W-1:0]  last_end_r, last_end_nxt;
  logic               have_lower_r, have_lower_nxt;
  logic [ADDR_W-1:0]  res_r, res_nxt;
  logic               legit_r, legit_nxt;
  logic [IW:0]        rd_idx_r, rd_idx_nxt;
  logic               vld_r, vld_nxt;
  logic [IW-1:0]      pidx_r, pidx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_res_r, out_res_nxt;
  logic               out_legit_r, out_legit_nxt;

  slot_wr_t           wr;
  logic [IW-1:0]      wr_idx;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_start;
  logic [ADDR_W-1:0]  rd_size;

  logic               rnd_start;
  logic               rnd_done;
  logic [ADDR_W-1:0]  rnd_need;

  logic [ADDR_W:0]    sum33;
  logic               hit_chk;
  logic               free_ok;
  logic               last_slot;
  logic [ADDR_W-1:0]  new_start;

  rsa_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk      (clk),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx_r[IW-1:0]),
    .rd_start (rd_start),
    .rd_size  (rd_size)
  );

  rsa_page_round #(.PAGE_BYTES(PAGE_BYTES)) u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rnd_start),
    .bytes (in_req.size_bytes),
    .done  (rnd_done),
    .need  (rnd_need)
  );

  assign in_req.ready           = (state_r == ST_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.result_address = out_res_r;
  assign out_rsp.legitimate     = out_legit_r;

  // shared end-of-region adder for allocate and check
  assign sum33     = {1'b0, rd_start} + {1'b0, rd_size};
  assign hit_chk   = (rd_start != '0) && (addr_r >= rd_start) && ({1'b0, addr_r} < sum33);
  assign free_ok   = (rd_start == '0) && ((rd_size == '0) || (need_r < rd_size));
  assign last_slot = (pidx_r == IW'(SLOTS - 1));
  assign new_start = have_lower_r ? last_end_r : base_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    live_nxt       = live_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    need_nxt       = need_r;
    last_end_nxt   = last_end_r;
    have_lower_nxt = have_lower_r;
    res_nxt        = res_r;
    legit_nxt      = legit_r;
    rd_idx_nxt     = rd_idx_r;
    vld_nxt        = 1'b0;
    pidx_nxt       = pidx_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    out_legit_nxt  = out_legit_r;
    wr             = '0;
    wr_idx         = '0;
    rd_en          = 1'b0;
    rnd_start      = 1'b0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr.we_start = 1'b1;
        wr.we_size  = 1'b1;
        wr_idx      = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          req_nxt        = in_req.req_type;
          addr_nxt       = in_req.address;
          res_nxt        = '0;
          legit_nxt      = 1'b0;
          have_lower_nxt = 1'b0;
          rd_idx_nxt     = '0;
          priority if (in_req.req_type == REQ_ALLOC) begin
            rnd_start = 1'b1;
            state_nxt = ST_ROUND;
          end else if ((in_req.req_type == REQ_RELEASE && in_req.address != '0) ||
                       in_req.req_type == REQ_CHECK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_done) begin
          need_nxt = rnd_need;
          if (live_r == '0) begin
            wr.we_start = 1'b1;
            wr.we_size  = 1'b1;
            wr.start    = base_r;
            wr.size     = rnd_need;
            wr_idx      = '0;
            live_nxt    = live_r + 1'b1;
            res_nxt     = base_r;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < (IW+1)'(SLOTS)) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          vld_nxt    = 1'b1;
          pidx_nxt   = rd_idx_r[IW-1:0];
        end
        if (vld_r) begin
          priority if (req_r == REQ_ALLOC) begin
            priority if (rd_start != '0) begin
              last_end_nxt   = sum33[ADDR_W-1:0];
              have_lower_nxt = 1'b1;
              if (last_slot) begin
                state_nxt = ST_FIN;
              end
            end else if (free_ok) begin
              // a wrapped start of zero is written too and still counts
              wr.we_start = 1'b1;
              wr.we_size  = 1'b1;
              wr.start    = new_start;
              wr.size     = need_r;
              wr_idx      = pidx_r;
              if (live_r != COUNT_MAX) begin
                live_nxt = live_r + 1'b1;
              end
              res_nxt   = new_start;
              vld_nxt   = 1'b0;
              state_nxt = ST_FIN;
            end else if (last_slot) begin
              state_nxt = ST_FIN;
            end
          end else if (req_r == REQ_RELEASE) begin
            if (rd_start == addr_r) begin
              wr.we_start = 1'b1;
              wr_idx      = pidx_r;
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
            end
            if (last_slot) begin
              state_nxt = ST_FIN;
            end
          end else begin
            if (hit_chk) begin
              legit_nxt = 1'b1;
            end
            if (last_slot) begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_legit_nxt = legit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      live_r      <= '0;
      base_r      <= BASE_RESET;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      live_r      <= live_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    need_r       <= need_nxt;
    last_end_r   <= last_end_nxt;
    have_lower_r <= have_lower_nxt;
    res_r        <= res_nxt;
    legit_r      <= legit_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pidx_r       <= pidx_nxt;
    out_res_r    <= out_res_nxt;
    out_legit_r  <= out_legit_nxt;
  end

  // table writes happen only while clearing, rounding or scanning
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we_start || wr.we_size) |-> (state_r != ST_IDLE && state_r != ST_FIN))
    else $error("slot table written outside clear, round or scan");

  // read data is consumed only within a scan
  a_vld_scan: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (state_r == ST_SCAN || state_r == ST_FIN))
    else $error("scan pipeline valid outside scan");

  // live count moves only as a consequence of allocate or release work
  a_live_src: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != $past(live_r)) |-> ($past(state_r) == ST_ROUND || $past(state_r) == ST_SCAN))
    else $error("live count changed outside allocate or release");

  // a response never carries both an address and a legitimate flag
  a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_legit_r && (out_res_r != '0)))
    else $error("response carries both address and legitimate flag");

endmodule

`default_nettype wire
